[sv/gtcf_pkg.sv]
package gtcf_pkg;

    // Field widths fixed by the command and result formats
    localparam int GEN_W          = 64;
    localparam int DEV_W          = 64;
    localparam int OWNER_FIELD_W  = 16;
    localparam int ERR_W          = 7;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 64;

    // Default producer id width and command queue depth
    localparam int OWNER_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    // Register index decoded from paddr[3]
    localparam logic REG_DEVICE_ID      = 1'b0;
    localparam logic REG_START_SIGNALED = 1'b1;

    typedef enum logic [2:0] {
        CMD_QUERY,
        CMD_WAIT,
        CMD_RESET,
        CMD_BIND,
        CMD_UNBIND,
        CMD_SIGNAL,
        CMD_DEVCHK,
        CMD_POLL
    } t_cmd;

    typedef enum logic [2:0] {
        RC_OK,
        RC_INVALID,
        RC_STALE,
        RC_BUSY,
        RC_OVERFLOW,
        RC_PERM,
        RC_BLOCK,
        RC_XDEV
    } t_rc;

    typedef enum logic [1:0] {
        ST_PENDING,
        ST_SIGNALED,
        ST_ERROR
    } t_fstate;

    // Classified request handed from the front to the back
    typedef struct packed {
        t_cmd                     cmd;
        logic [GEN_W-1:0]         gen;
        logic                     gen_zero;
        logic [OWNER_FIELD_W-1:0] owner;
        logic                     owner_zero;
        logic                     s_neg;
        logic [ERR_W-1:0]         status;
        logic                     status_nz;
        logic                     xdev;
        logic                     want_in;
        logic                     want_rdnorm;
    } t_item;

    // Fence re-creation event from a start_signaled write
    typedef struct packed {
        logic recreate;
        logic signaled;
    } t_cfg_evt;

    // Queue status seen by the top level
    typedef struct packed {
        logic valid;
        logic full;
    } t_qstat;

endpackage

[sv/gtcf_front.sv]
module gtcf_front #(
    parameter int OWNER_BITS = gtcf_pkg::OWNER_BITS_DEF
) (
    input  logic                                   i_valid,
    input  logic [2:0]                             i_cmd,
    input  logic [gtcf_pkg::GEN_W-1:0]             i_gen_req,
    input  logic [gtcf_pkg::OWNER_FIELD_W-1:0]     i_owner_id,
    input  logic signed [7:0]                      i_signal_status,
    input  logic [gtcf_pkg::DEV_W-1:0]             i_device_req,
    input  logic                                   i_want_in,
    input  logic                                   i_want_rdnorm,
    input  logic [gtcf_pkg::DEV_W-1:0]             i_device_id,
    input  logic                                   i_q_full,
    output logic                                   o_ready,
    output logic                                   o_push,
    output gtcf_pkg::t_item                        o_item
);

    localparam int OW = (OWNER_BITS < gtcf_pkg::OWNER_FIELD_W) ?
                        OWNER_BITS : gtcf_pkg::OWNER_FIELD_W;
    localparam logic [gtcf_pkg::OWNER_FIELD_W-1:0] OWNER_MASK =
        {gtcf_pkg::OWNER_FIELD_W{1'b1}} >> (gtcf_pkg::OWNER_FIELD_W - OW);

    logic [gtcf_pkg::OWNER_FIELD_W-1:0] owner_m;

    // Take a request whenever the queue has room
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign owner_m = i_owner_id & OWNER_MASK;

    // Classify the input-only checks ahead of the fence logic
    always_comb begin
        o_item.cmd         = gtcf_pkg::t_cmd'(i_cmd);
        o_item.gen         = i_gen_req;
        o_item.gen_zero    = (i_gen_req == '0);
        o_item.owner       = owner_m;
        o_item.owner_zero  = (owner_m == '0);
        o_item.s_neg       = i_signal_status[7];
        o_item.status      = i_signal_status[6:0];
        o_item.status_nz   = (i_signal_status[6:0] != '0);
        o_item.xdev        = (i_device_req != i_device_id);
        o_item.want_in     = i_want_in;
        o_item.want_rdnorm = i_want_rdnorm;
    end

endmodule

[sv/gtcf_queue.sv]
module gtcf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gtcf_pkg::t_item i_item,
    input  logic            i_pop,
    output gtcf_pkg::t_item o_item,
    output gtcf_pkg::t_qstat o_stat
);

    localparam int DEPTH = gtcf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    gtcf_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign do_push      = i_push && (r_count != FULL);
    assign do_pop       = i_pop && (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == FULL);

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Store pushed requests
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

[sv/gtcf_back.sv]
module gtcf_back #(
    parameter int OWNER_BITS = gtcf_pkg::OWNER_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gtcf_pkg::t_cfg_evt             i_cfg_evt,
    input  gtcf_pkg::t_qstat               i_qstat,
    input  gtcf_pkg::t_item                i_item,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [2:0]                     o_result_code,
    output logic [gtcf_pkg::GEN_W-1:0]     o_gen_out,
    output logic [1:0]                     o_state_out,
    output logic [gtcf_pkg::ERR_W-1:0]     o_error_out,
    output logic                           o_ready_in,
    output logic                           o_ready_rdnorm,
    output logic                           o_ready_err
);

    localparam int OW = (OWNER_BITS < gtcf_pkg::OWNER_FIELD_W) ?
                        OWNER_BITS : gtcf_pkg::OWNER_FIELD_W;

    // Fence state
    logic [gtcf_pkg::GEN_W-1:0] r_gen,   n_gen;
    gtcf_pkg::t_fstate          r_state, n_state;
    logic [OW-1:0]              r_owner, n_owner;
    logic [gtcf_pkg::ERR_W-1:0] r_err,   n_err;

    // Result slot
    logic                       r_valid;
    gtcf_pkg::t_rc              r_rc,    n_rc;
    logic [gtcf_pkg::GEN_W-1:0] r_sgen,  n_sgen;
    gtcf_pkg::t_fstate          r_sst,   n_sst;
    logic [gtcf_pkg::ERR_W-1:0] r_serr,  n_serr;
    logic                       r_rin,   n_rin;
    logic                       r_rrd,   n_rrd;
    logic                       r_rerr,  n_rerr;

    logic cur;
    logic pending;
    logic bound;
    logic owner_ok;
    logic gen_max;

    // Pop when the slot is empty or its result leaves this cycle
    assign o_pop    = i_qstat.valid && (!r_valid || i_ready);
    assign cur      = (i_item.gen == r_gen);
    assign pending  = (r_state == gtcf_pkg::ST_PENDING);
    assign bound    = (r_owner != '0);
    assign owner_ok = !i_item.owner_zero && (r_owner == i_item.owner[OW-1:0]);
    assign gen_max  = &r_gen;

    // Check the command in order and form the update
    always_comb begin
        n_gen   = r_gen;
        n_state = r_state;
        n_owner = r_owner;
        n_err   = r_err;
        n_rc    = gtcf_pkg::RC_OK;
        n_sgen  = '0;
        n_sst   = gtcf_pkg::ST_PENDING;
        n_serr  = '0;
        n_rin   = 1'b0;
        n_rrd   = 1'b0;
        n_rerr  = 1'b0;
        case (i_item.cmd)
            gtcf_pkg::CMD_QUERY: begin
                if (!i_item.gen_zero && !cur) begin
                    n_rc = gtcf_pkg::RC_STALE;
                end else begin
                    n_sgen = r_gen;
                    n_sst  = r_state;
                    n_serr = r_err;
                end
            end
            gtcf_pkg::CMD_WAIT: begin
                if (i_item.gen_zero) begin
                    n_rc = gtcf_pkg::RC_INVALID;
                end else if (!cur) begin
                    n_rc = gtcf_pkg::RC_STALE;
                end else if (pending) begin
                    n_rc = gtcf_pkg::RC_BLOCK;
                end else begin
                    n_sgen = r_gen;
                    n_sst  = r_state;
                    n_serr = r_err;
                end
            end
            gtcf_pkg::CMD_RESET: begin
                if (i_item.gen_zero) begin
                    n_rc = gtcf_pkg::RC_INVALID;
                end else if (!cur) begin
                    n_rc = gtcf_pkg::RC_STALE;
                end else if (bound) begin
                    n_rc = gtcf_pkg::RC_BUSY;
                end else if (gen_max) begin
                    n_rc = gtcf_pkg::RC_OVERFLOW;
                end else begin
                    n_gen   = r_gen + 1'b1;
                    n_state = gtcf_pkg::ST_PENDING;
                    n_err   = '0;
                    n_sgen  = r_gen + 1'b1;
                    n_sst   = gtcf_pkg::ST_PENDING;
                end
            end
            gtcf_pkg::CMD_BIND: begin
                if (i_item.owner_zero || i_item.gen_zero) begin
                    n_rc = gtcf_pkg::RC_INVALID;
                end else if (!cur) begin
                    n_rc = gtcf_pkg::RC_STALE;
                end else if (!pending || bound) begin
                    n_rc = gtcf_pkg::RC_BUSY;
                end else begin
                    n_owner = i_item.owner[OW-1:0];
                end
            end
            gtcf_pkg::CMD_UNBIND: begin
                if (!cur) begin
                    n_rc = gtcf_pkg::RC_STALE;
                end else if (!owner_ok) begin
                    n_rc = gtcf_pkg::RC_PERM;
                end else begin
                    n_owner = '0;
                end
            end
            gtcf_pkg::CMD_SIGNAL: begin
                if (i_item.s_neg) begin
                    n_rc = gtcf_pkg::RC_INVALID;
                end else if (!cur) begin
                    n_rc = gtcf_pkg::RC_STALE;
                end else if (!owner_ok) begin
                    n_rc = gtcf_pkg::RC_PERM;
                end else begin
                    n_state = i_item.status_nz ? gtcf_pkg::ST_ERROR : gtcf_pkg::ST_SIGNALED;
                    n_err   = i_item.status;
                    n_owner = '0;
                end
            end
            gtcf_pkg::CMD_DEVCHK: begin
                if (i_item.xdev) begin
                    n_rc = gtcf_pkg::RC_XDEV;
                end
            end
            gtcf_pkg::CMD_POLL: begin
                n_rin  = i_item.want_in && !pending;
                n_rrd  = i_item.want_rdnorm && !pending;
                n_rerr = (r_state == gtcf_pkg::ST_ERROR);
            end
            default: begin
                n_rc = gtcf_pkg::RC_OK;
            end
        endcase
    end

    // Update fence state on each pop; re-create it on a start_signaled write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen   <= gtcf_pkg::GEN_W'(1);
            r_state <= gtcf_pkg::ST_PENDING;
            r_owner <= '0;
            r_err   <= '0;
        end else if (i_cfg_evt.recreate) begin
            r_gen   <= gtcf_pkg::GEN_W'(1);
            r_state <= i_cfg_evt.signaled ? gtcf_pkg::ST_SIGNALED : gtcf_pkg::ST_PENDING;
            r_owner <= '0;
            r_err   <= '0;
        end else if (o_pop) begin
            r_gen   <= n_gen;
            r_state <= n_state;
            r_owner <= n_owner;
            r_err   <= n_err;
        end
    end

    // Track the result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rc   <= n_rc;
            r_sgen <= n_sgen;
            r_sst  <= n_sst;
            r_serr <= n_serr;
            r_rin  <= n_rin;
            r_rrd  <= n_rrd;
            r_rerr <= n_rerr;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_code  = r_rc;
    assign o_gen_out      = r_sgen;
    assign o_state_out    = r_sst;
    assign o_error_out    = r_serr;
    assign o_ready_in     = r_rin;
    assign o_ready_rdnorm = r_rrd;
    assign o_ready_err    = r_rerr;

endmodule

[sv/generation_tagged_completion_fence.sv]
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+--------------------------------------------
// command   | i_cmd_valid / o_cmd_ready      | i_cmd, i_gen_req, i_owner_id, i_signal_status,
//           |                                | i_device_req, i_want_in, i_want_rdnorm
// response  | o_rsp_valid / i_rsp_ready      | o_result_code, o_gen_out, o_state_out,
//           |                                | o_error_out, o_ready_in, o_ready_rdnorm,
//           |                                | o_ready_err
// config    | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// One command per cycle sustained while responses are taken; a taken command is registered in the
// two-entry command queue and then in the response register before its response appears.
// The fence update (64-bit generation compare and increment) runs in the single back stage.
// Reset is synchronous and active low; it empties the queue and response slot at once.
// A stalled response holds in its register while the queue keeps taking commands until full.
module generation_tagged_completion_fence #(
    parameter int OWNER_BITS = gtcf_pkg::OWNER_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                i_cmd_valid,
    output logic                                o_cmd_ready,
    input  logic [2:0]                          i_cmd,
    input  logic [gtcf_pkg::GEN_W-1:0]          i_gen_req,
    input  logic [gtcf_pkg::OWNER_FIELD_W-1:0]  i_owner_id,
    input  logic signed [7:0]                   i_signal_status,
    input  logic [gtcf_pkg::DEV_W-1:0]          i_device_req,
    input  logic                                i_want_in,
    input  logic                                i_want_rdnorm,
    // response channel
    output logic                                o_rsp_valid,
    input  logic                                i_rsp_ready,
    output logic [2:0]                          o_result_code,
    output logic [gtcf_pkg::GEN_W-1:0]          o_gen_out,
    output logic [1:0]                          o_state_out,
    output logic [gtcf_pkg::ERR_W-1:0]          o_error_out,
    output logic                                o_ready_in,
    output logic                                o_ready_rdnorm,
    output logic                                o_ready_err,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gtcf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gtcf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gtcf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [gtcf_pkg::DEV_W-1:0] r_device_id;
    logic                       r_start_signaled;
    logic                       cfg_wr;
    gtcf_pkg::t_cfg_evt         cfg_evt;
    logic                       q_push;
    logic                       q_pop;
    gtcf_pkg::t_item            front_item;
    gtcf_pkg::t_item            q_item;
    gtcf_pkg::t_qstat           q_stat;

    // Decode register writes
    assign pready           = 1'b1;
    assign cfg_wr           = psel && penable && pwrite;
    assign cfg_evt.recreate = cfg_wr && (paddr[3] == gtcf_pkg::REG_START_SIGNALED);
    assign cfg_evt.signaled = pwdata[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id      <= gtcf_pkg::DEV_W'(1);
            r_start_signaled <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[3] == gtcf_pkg::REG_DEVICE_ID) begin
                r_device_id <= pwdata;
            end else begin
                r_start_signaled <= pwdata[0];
            end
        end
    end

    // Return register contents on read
    always_comb begin
        if (paddr[3] == gtcf_pkg::REG_DEVICE_ID) begin
            prdata = r_device_id;
        end else begin
            prdata = {{(gtcf_pkg::APB_DATA_W-1){1'b0}}, r_start_signaled};
        end
    end

    gtcf_front #(
        .OWNER_BITS (OWNER_BITS)
    ) u_front (
        .i_valid         (i_cmd_valid),
        .i_cmd           (i_cmd),
        .i_gen_req       (i_gen_req),
        .i_owner_id      (i_owner_id),
        .i_signal_status (i_signal_status),
        .i_device_req    (i_device_req),
        .i_want_in       (i_want_in),
        .i_want_rdnorm   (i_want_rdnorm),
        .i_device_id     (r_device_id),
        .i_q_full        (q_stat.full),
        .o_ready         (o_cmd_ready),
        .o_push          (q_push),
        .o_item          (front_item)
    );

    gtcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    gtcf_back #(
        .OWNER_BITS (OWNER_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_evt      (cfg_evt),
        .i_qstat        (q_stat),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .o_valid        (o_rsp_valid),
        .i_ready        (i_rsp_ready),
        .o_result_code  (o_result_code),
        .o_gen_out      (o_gen_out),
        .o_state_out    (o_state_out),
        .o_error_out    (o_error_out),
        .o_ready_in     (o_ready_in),
        .o_ready_rdnorm (o_ready_rdnorm),
        .o_ready_err    (o_ready_err)
    );

`ifndef SYNTHESIS
    // A request into an empty pipe with a free response side passes the queue and the response register to o_rsp_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && o_cmd_ready && !q_stat.valid && (!o_rsp_valid || i_rsp_ready))
        |=> ##1 o_rsp_valid)
        else $error("response missing two cycles after request into idle pipe");

    // A new response only follows a queued request
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(q_stat.valid))
        else $error("response raised without a queued request");

    // Reset empties the queue and the response slot
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_rsp_valid && !q_stat.valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

[bench/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gtcf_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // One fence request as it goes out on the command channel
    typedef struct {
        t_cmd                     cmd;
        logic [GEN_W-1:0]         gen;
        logic [OWNER_FIELD_W-1:0] owner;
        logic signed [7:0]        status;
        logic [DEV_W-1:0]         dev;
        logic                     want_in;
        logic                     want_rdnorm;
    } t_fence_req;

    // One reply from the response channel
    typedef struct {
        logic [2:0]       rc;
        logic [GEN_W-1:0] gen;
        logic [1:0]       st;
        logic [ERR_W-1:0] err;
        logic             rdy_in;
        logic             rdy_rdnorm;
        logic             rdy_err;
    } t_fence_rsp;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cmd_valid = 1'b0;
    logic                     o_cmd_ready;
    logic [2:0]               i_cmd = '0;
    logic [GEN_W-1:0]         i_gen_req = '0;
    logic [OWNER_FIELD_W-1:0] i_owner_id = '0;
    logic signed [7:0]        i_signal_status = '0;
    logic [DEV_W-1:0]         i_device_req = '0;
    logic                     i_want_in = 1'b0;
    logic                     i_want_rdnorm = 1'b0;
    logic                     o_rsp_valid;
    logic                     i_rsp_ready = 1'b0;
    logic [2:0]               o_result_code;
    logic [GEN_W-1:0]         o_gen_out;
    logic [1:0]               o_state_out;
    logic [ERR_W-1:0]         o_error_out;
    logic                     o_ready_in;
    logic                     o_ready_rdnorm;
    logic                     o_ready_err;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0]    pwdata = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    // Shadow copy of the fence and its registers
    logic [DEV_W-1:0]         cfg_device = 64'd1;
    logic                     cfg_start = 1'b0;
    logic [GEN_W-1:0]         fence_gen;
    t_fstate                  fence_st;
    logic [OWNER_FIELD_W-1:0] fence_owner;
    logic [ERR_W-1:0]         fence_err;

    t_fence_rsp  due_replies[$];
    int unsigned bad_replies = 0;
    int unsigned idle_cycles = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_left = 0;
    logic [2:0]  rx_tick = '0;

    generation_tagged_completion_fence dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (i_cmd_valid),
        .o_cmd_ready    (o_cmd_ready),
        .i_cmd          (i_cmd),
        .i_gen_req      (i_gen_req),
        .i_owner_id     (i_owner_id),
        .i_signal_status(i_signal_status),
        .i_device_req   (i_device_req),
        .i_want_in      (i_want_in),
        .i_want_rdnorm  (i_want_rdnorm),
        .o_rsp_valid    (o_rsp_valid),
        .i_rsp_ready    (i_rsp_ready),
        .o_result_code  (o_result_code),
        .o_gen_out      (o_gen_out),
        .o_state_out    (o_state_out),
        .o_error_out    (o_error_out),
        .o_ready_in     (o_ready_in),
        .o_ready_rdnorm (o_ready_rdnorm),
        .o_ready_err    (o_ready_err),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    // Rebuild the fence as a fresh object at generation one
    function automatic void fence_recreate();
        fence_gen   = 64'd1;
        fence_st    = cfg_start ? ST_SIGNALED : ST_PENDING;
        fence_owner = '0;
        fence_err   = '0;
    endfunction

    function automatic t_fence_rsp fence_view();
        t_fence_rsp o;
        o.rc         = RC_OK;
        o.gen        = fence_gen;
        o.st         = fence_st;
        o.err        = fence_err;
        o.rdy_in     = 1'b0;
        o.rdy_rdnorm = 1'b0;
        o.rdy_err    = 1'b0;
        return o;
    endfunction

    // Apply one request to the shadow fence and return the reply it earns
    function automatic t_fence_rsp fence_outcome(t_fence_req r);
        t_fence_rsp o;
        logic       current;
        current      = (r.gen == fence_gen);
        o.rc         = RC_OK;
        o.gen        = '0;
        o.st         = '0;
        o.err        = '0;
        o.rdy_in     = 1'b0;
        o.rdy_rdnorm = 1'b0;
        o.rdy_err    = 1'b0;
        case (r.cmd)
            CMD_QUERY: begin
                if (r.gen != 0 && !current) o.rc = RC_STALE;
                else o = fence_view();
            end
            CMD_WAIT: begin
                if (r.gen == 0) o.rc = RC_INVALID;
                else if (current && fence_st == ST_PENDING) o.rc = RC_BLOCK;
                else if (!current) o.rc = RC_STALE;
                else o = fence_view();
            end
            CMD_RESET: begin
                if (r.gen == 0) o.rc = RC_INVALID;
                else if (!current) o.rc = RC_STALE;
                else if (fence_owner != 0) o.rc = RC_BUSY;
                else if (&fence_gen) o.rc = RC_OVERFLOW;
                else begin
                    fence_gen = fence_gen + 64'd1;
                    fence_st  = ST_PENDING;
                    fence_err = '0;
                    o = fence_view();
                end
            end
            CMD_BIND: begin
                if (r.owner == 0 || r.gen == 0) o.rc = RC_INVALID;
                else if (!current) o.rc = RC_STALE;
                else if (fence_st != ST_PENDING || fence_owner != 0) o.rc = RC_BUSY;
                else fence_owner = r.owner;
            end
            CMD_UNBIND: begin
                if (!current) o.rc = RC_STALE;
                else if (r.owner == 0 || fence_owner != r.owner) o.rc = RC_PERM;
                else fence_owner = '0;
            end
            CMD_SIGNAL: begin
                if (r.status < 0) o.rc = RC_INVALID;
                else if (!current) o.rc = RC_STALE;
                else if (r.owner == 0 || fence_owner != r.owner) o.rc = RC_PERM;
                else begin
                    fence_st    = (r.status != 0) ? ST_ERROR : ST_SIGNALED;
                    fence_err   = r.status[ERR_W-1:0];
                    fence_owner = '0;
                end
            end
            CMD_DEVCHK: begin
                if (r.dev != cfg_device) o.rc = RC_XDEV;
            end
            default: begin
                if (fence_st != ST_PENDING) begin
                    o.rdy_in     = r.want_in;
                    o.rdy_rdnorm = r.want_rdnorm;
                end
                o.rdy_err = (fence_st == ST_ERROR);
            end
        endcase
        return o;
    endfunction

    function automatic t_fence_req fence_req(t_cmd c, logic [GEN_W-1:0] g,
                                             logic [OWNER_FIELD_W-1:0] own,
                                             logic signed [7:0] s, logic [DEV_W-1:0] d,
                                             logic wi, logic wr);
        t_fence_req r;
        r.cmd         = c;
        r.gen         = g;
        r.owner       = own;
        r.status      = s;
        r.dev         = d;
        r.want_in     = wi;
        r.want_rdnorm = wr;
        return r;
    endfunction

    // Mostly follow the fence lifecycle, with some malformed and stale noise mixed in
    function automatic t_fence_req random_req();
        t_fence_req  r;
        int unsigned roll;
        roll          = $urandom_range(0, 99);
        r.cmd         = t_cmd'($urandom_range(0, 7));
        r.gen         = fence_gen;
        r.owner       = fence_owner;
        r.status      = 8'($urandom);
        r.dev         = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : cfg_device;
        r.want_in     = 1'($urandom);
        r.want_rdnorm = 1'($urandom);
        if (roll < 70) begin
            if (fence_st != ST_PENDING) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: r.cmd = CMD_RESET;
                    4, 5:       r.cmd = CMD_WAIT;
                    6, 7:       r.cmd = CMD_POLL;
                    8:          r.cmd = CMD_QUERY;
                    default:    r.cmd = CMD_DEVCHK;
                endcase
            end else if (fence_owner == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        r.cmd   = CMD_BIND;
                        r.owner = 16'($urandom_range(1, 65535));
                    end
                    5, 6:    r.cmd = CMD_RESET;
                    7:       r.cmd = CMD_WAIT;
                    8:       r.cmd = CMD_POLL;
                    default: r.cmd = CMD_QUERY;
                endcase
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: r.cmd = CMD_SIGNAL;
                    6, 7:             r.cmd = CMD_UNBIND;
                    8:                r.cmd = CMD_BIND;
                    default:          r.cmd = CMD_POLL;
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:    r.status = 8'sd0;
                    4, 5, 6, 7, 8: r.status = 8'($urandom_range(1, 127));
                    default:       ;
                endcase
            end
        end else begin
            case ($urandom_range(0, 4))
                0:       r.gen = '0;
                1:       r.gen = fence_gen + 64'd1;
                2:       r.gen = fence_gen - 64'd1;
                3:       r.gen = {$urandom, $urandom};
                default: ;
            endcase
            case ($urandom_range(0, 3))
                0:       r.owner = '0;
                1:       r.owner = 16'($urandom);
                default: ;
            endcase
        end
        return r;
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_request(t_fence_req r);
        i_cmd_valid     <= 1'b1;
        i_cmd           <= r.cmd;
        i_gen_req       <= r.gen;
        i_owner_id      <= r.owner;
        i_signal_status <= r.status;
        i_device_req    <= r.dev;
        i_want_in       <= r.want_in;
        i_want_rdnorm   <= r.want_rdnorm;
        do @(posedge i_clk); while (o_cmd_ready !== 1'b1);
        due_replies.push_back(fence_outcome(r));
    endtask

    task automatic hold_requests(int unsigned cycles);
        i_cmd_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending and let every outstanding reply come back
    task automatic wait_replies_done();
        i_cmd_valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Register write: setup cycle, access cycle, then back to idle
    task automatic write_reg(logic idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_DEVICE_ID) begin
            cfg_device = value;
        end else begin
            cfg_start = value[0];
            fence_recreate();
        end
        @(posedge i_clk);
    endtask

    // Walk every command through most of its error checks and, for all but UNBIND, its success path.
    // Overflow needs a generation at the maximum, which no request sequence reaches.
    task automatic test_directed_cases();
        logic [GEN_W-1:0] gmax;
        gmax = '1;
        send_request(fence_req(CMD_QUERY,  0,    16'h0000, 8'sd0,    64'd0, 1'b1, 1'b1));
        send_request(fence_req(CMD_QUERY,  gmax, 16'h0000, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_WAIT,   0,    16'h0000, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_WAIT,   1,    16'h0000, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_WAIT,   2,    16'h0000, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_POLL,   1,    16'h0000, 8'sd0,    64'd0, 1'b1, 1'b1));
        send_request(fence_req(CMD_DEVCHK, 0,    16'h0000, 8'sd0,    64'd1, 1'b0, 1'b0));
        send_request(fence_req(CMD_DEVCHK, 0,    16'h0000, 8'sd0,    gmax,  1'b0, 1'b0));
        send_request(fence_req(CMD_BIND,   1,    16'h0000, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_BIND,   0,    16'hFFFF, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_BIND,   1,    16'hFFFF, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_BIND,   1,    16'h0005, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_RESET,  1,    16'h0000, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_UNBIND, 1,    16'h0007, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_SIGNAL, 1,    16'hFFFF, -8'sd128, 64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_SIGNAL, 2,    16'hFFFF, 8'sd127,  64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_SIGNAL, 1,    16'h0000, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_SIGNAL, 1,    16'hFFFF, 8'sd127,  64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_POLL,   1,    16'h0000, 8'sd0,    64'd0, 1'b1, 1'b0));
        send_request(fence_req(CMD_WAIT,   1,    16'h0000, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_BIND,   1,    16'h0009, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_RESET,  0,    16'h0000, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_RESET,  1,    16'h0000, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_UNBIND, 1,    16'h0009, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_BIND,   2,    16'h8000, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_SIGNAL, 2,    16'h8000, 8'sd0,    64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_POLL,   2,    16'h0000, 8'sd0,    64'd0, 1'b0, 1'b1));
    endtask

    // Sweep device id and creation state, zero and all-ones device id included
    task automatic test_register_settings();
        logic [DEV_W-1:0] dev_list[4];
        logic             start_list[4];
        dev_list   = '{64'd0, {DEV_W{1'b1}}, {$urandom, $urandom}, 64'd1};
        start_list = '{1'b1, 1'b0, 1'b1, 1'b0};
        // leave an owner bound so re-creation has something to clear
        send_request(fence_req(CMD_RESET, fence_gen, 16'h0000, 8'sd0, 64'd0, 1'b0, 1'b0));
        send_request(fence_req(CMD_BIND,  fence_gen, 16'h0003, 8'sd0, 64'd0, 1'b0, 1'b0));
        for (int k = 0; k < 4; k++) begin
            wait_replies_done();
            write_reg(REG_DEVICE_ID, dev_list[k]);
            write_reg(REG_START_SIGNALED, {63'd0, start_list[k]});
            send_request(fence_req(CMD_DEVCHK, 0, 16'h0000, 8'sd0, cfg_device, 1'b0, 1'b0));
            send_request(fence_req(CMD_DEVCHK, 0, 16'h0000, 8'sd0,
                                   cfg_device ^ (64'd1 << $urandom_range(0, 63)), 1'b0, 1'b0));
            send_request(fence_req(CMD_QUERY,  0, 16'h0000, 8'sd0, 64'd0, 1'b0, 1'b0));
            send_request(fence_req(CMD_POLL,   1, 16'h0000, 8'sd0, 64'd0, 1'b1, 1'b1));
        end
    endtask

    // Random traffic in bursts with random gaps
    task automatic random_traffic(int unsigned count);
        int unsigned burst;
        int unsigned gap;
        burst = 0;
        for (int unsigned n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 3) == 0) ? 0 :
                        $urandom_range(1, ($urandom_range(0, 4) == 0) ? 15 : 3);
                if (gap != 0) hold_requests(gap);
            end
            send_request(random_req());
            burst--;
        end
    endtask

    // Random rounds, draining and changing the registers between them
    task automatic test_random_rounds();
        for (int r = 0; r < 4; r++) begin
            random_traffic(255);
            wait_replies_done();
            if ($urandom_range(0, 2) != 0) write_reg(REG_DEVICE_ID, {$urandom, $urandom});
            write_reg(REG_START_SIGNALED, {63'd0, 1'($urandom_range(0, 1))});
        end
    endtask

    task automatic show_reply(string tag, t_fence_rsp x);
        $display("  %s rc=%0d gen=%h st=%0d err=%0d rdy_in=%b rdy_rdnorm=%b rdy_err=%b",
                 tag, x.rc, x.gen, x.st, x.err, x.rdy_in, x.rdy_rdnorm, x.rdy_err);
    endtask

    // Response stall pattern: a random mode is held for a random stretch, then redrawn
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 3'd1;
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(8, 60);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       i_rsp_ready <= 1'b1;
            1:       i_rsp_ready <= 1'($urandom_range(0, 1));
            2:       i_rsp_ready <= ($urandom_range(0, 3) == 0);
            default: i_rsp_ready <= (rx_tick < 3'd2);
        endcase
    end

    // Compare each accepted reply against the oldest prediction
    always @(posedge i_clk) begin : reply_check
        t_fence_rsp got;
        t_fence_rsp want;
        if (i_rst_n && o_rsp_valid === 1'b1 && i_rsp_ready) begin
            got.rc         = o_result_code;
            got.gen        = o_gen_out;
            got.st         = o_state_out;
            got.err        = o_error_out;
            got.rdy_in     = o_ready_in;
            got.rdy_rdnorm = o_ready_rdnorm;
            got.rdy_err    = o_ready_err;
            if (due_replies.size() == 0) begin
                bad_replies++;
                if (bad_replies <= 10) begin
                    $display("reply at %0t with no request outstanding", $realtime);
                    show_reply("got: ", got);
                end
            end else begin
                want = due_replies.pop_front();
                if (got.rc !== want.rc || got.gen !== want.gen || got.st !== want.st ||
                    got.err !== want.err || got.rdy_in !== want.rdy_in ||
                    got.rdy_rdnorm !== want.rdy_rdnorm || got.rdy_err !== want.rdy_err) begin
                    bad_replies++;
                    if (bad_replies <= 10) begin
                        $display("reply mismatch at %0t", $realtime);
                        show_reply("want:", want);
                        show_reply("got: ", got);
                    end
                end
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge i_clk) begin
        if ((i_cmd_valid && o_cmd_ready === 1'b1) || (o_rsp_valid === 1'b1 && i_rsp_ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        fence_recreate();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_register_settings();
        test_random_rounds();
        wait_replies_done();
        repeat (10) @(posedge i_clk);
        if (bad_replies == 0 && due_replies.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
